@@ hw/rtl/scma_pkg.sv @@
`timescale 1ns / 1ps
package scma_pkg;
  localparam int ADDR_BITS = 16;
  localparam int MAX_SEGMENTS = 8;

  localparam int ACTION_W = 2;
  localparam int LEN_W = 4;
  localparam int DATA_W = 64;
  localparam int SEGIDX_W = 3;
  localparam int SEGADDR_W = ADDR_BITS + 1;
  localparam int ALIGN_W = 9;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STORE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEGWR = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PERM = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MOVED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 1'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_BITS-1:0] addr;
    logic [LEN_W-1:0] access_len;
    logic [DATA_W-1:0] store_data;
    logic [SEGIDX_W-1:0] seg_index;
    logic [SEGADDR_W-1:0] seg_origin;
    logic [SEGADDR_W-1:0] seg_end;
    logic seg_read_ok;
    logic seg_write_ok;
    logic [ALIGN_W-1:0] seg_align;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEGADDR_W-1:0] end_addr;
    logic [DATA_W-1:0] load_data;
  } out_item_t;
endpackage

@@ hw/rtl/scma_if.sv @@
`timescale 1ns / 1ps
interface scma_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/scma_div.sv @@
`timescale 1ns / 1ps
module scma_div import scma_pkg::*; #(
  parameter int W = 32,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [W-1:0]  quo
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt;
  logic [DW:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0] trial;

  assign trial = {rem_r[DW-1:0], q_r[W-1]};
  assign busy = (cnt_r != '0);
  assign quo = q_r;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CW'(W);
    end else if (busy) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end
endmodule

@@ hw/rtl/segment_checked_memory_access.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Payload
// in       sink       action, addr, access_len, store_data, seg_* fields
// out      source     status, end_addr, load_data
// cfg      write      cfg_we, cfg_idx, cfg_data (mem_length, segment_count)
// One item at a time. A load or store searches the segment table, aligns
// the address with the bit-serial divider, searches again, then reads or
// writes memory one byte at a time and offers the result. Out of memory
// ends early. A segment write updates the table and then offers a result.
// Synchronous reset clears the segment table, with alignments reset to 1.
// Memory contents are undefined after reset. A stalled result holds.
module segment_checked_memory_access import scma_pkg::*; #(
  parameter int MAX_ACCESS_BYTES = 8,
  parameter int MAX_ALIGN = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  scma_if.sink                  in_ch,
  scma_if.source                out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int AW = ADDR_BITS;
  localparam int EW = AW + 1;
  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);
  localparam int BW = (MAX_ACCESS_BYTES > 1) ? $clog2(MAX_ACCESS_BYTES) : 1;
  localparam int LW = $clog2(MAX_ACCESS_BYTES + 1);
  localparam int GW = $clog2(MAX_ALIGN + 1);
  localparam int QW = EW + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_SRCH1 = 8'b00000010, S_DIV = 8'b00000100,
    S_DIVW = 8'b00001000, S_SRCH2 = 8'b00010000, S_MEM = 8'b00100000,
    S_MEMW = 8'b01000000, S_OUT = 8'b10000000
  } state_t;

  state_t st_r, st_nxt;
  logic [EW-1:0] memlen_r;
  logic [3:0] segcnt_r;
  logic [EW-1:0] org_r [MAX_SEGMENTS];
  logic [EW-1:0] end_r [MAX_SEGMENTS];
  logic [1:0] perm_r [MAX_SEGMENTS];
  logic [GW-1:0] algn_r [MAX_SEGMENTS];
  logic [7:0] mem [2**AW];

  in_item_t it_r;
  logic [LW-1:0] len_r;
  logic [SW-1:0] si_r;
  logic found_r;
  logic [SW-1:0] seg_r;
  logic [EW:0] base_r;
  logic [GW-1:0] alg_r;
  logic [LW-1:0] bi_r;
  logic [7:0] rd_r;
  logic [STATUS_W-1:0] status_r;
  logic [SEGADDR_W-1:0] eaddr_r;
  logic [DATA_W-1:0] ld_r;
  logic div_start;
  logic div_busy;
  logic [QW-1:0] quo;
  logic [EW+GW:0] prod;
  logic [SCW-1:0] cnt_lim;
  logic [EW-1:0] lim;
  logic [EW:0] e_cur;
  logic hit;
  logic [AW-1:0] maddr;

  scma_div #(.W(QW), .DW(GW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(QW'({1'b0, it_r.addr[AW-1:0]}) + QW'(alg_r) - QW'(1)),
    .den(alg_r), .busy(div_busy), .quo(quo)
  );

  assign prod = (EW + GW + 1)'(quo) * (EW + GW + 1)'(alg_r);
  assign cnt_lim = (segcnt_r > 4'(MAX_SEGMENTS)) ? SCW'(MAX_SEGMENTS) : SCW'(segcnt_r);
  assign lim = (memlen_r > EW'(2**AW)) ? EW'(2**AW) : memlen_r;
  assign e_cur = base_r + (EW + 1)'(len_r);
  assign hit = (org_r[si_r] <= base_r[EW-1:0]) && (e_cur <= {1'b0, end_r[si_r]});
  assign maddr = AW'(base_r + (EW + 1)'(bi_r));

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data = '{status: status_r, end_addr: eaddr_r, load_data: ld_r};
  assign div_start = (st_r == S_DIV);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_ch.valid) st_nxt = (in_ch.data.action == ACT_LOAD ||
                  in_ch.data.action == ACT_STORE) ? S_SRCH1 : S_OUT;
      S_SRCH1: if (e_cur > {1'b0, lim}) st_nxt = S_OUT;
               else if (hit || SCW'(si_r) + 1'b1 >= cnt_lim) st_nxt = S_DIV;
      S_DIV: st_nxt = S_DIVW;
      S_DIVW: if (!div_busy) st_nxt = S_SRCH2;
      S_SRCH2: if (status_r != ST_OK ||
                   prod[EW:0] == (EW + 1)'(it_r.addr[AW-1:0]) ||
                   e_cur > {1'b0, lim} ||
                   hit || SCW'(si_r) + 1'b1 >= cnt_lim) st_nxt = S_MEM;
      S_MEM: st_nxt = S_MEMW;
      S_MEMW: if (status_r != ST_OK || bi_r >= len_r) st_nxt = S_OUT;
              else st_nxt = S_MEM;
      S_OUT: if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      memlen_r <= EW'(2**AW);
      segcnt_r <= '0;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        org_r[i] <= '0;
        end_r[i] <= '0;
        perm_r[i] <= '0;
        algn_r[i] <= GW'(1);
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_we && cfg_idx == CFG_MEM_LENGTH) memlen_r <= EW'(cfg_data);
      if (cfg_we && cfg_idx == CFG_SEG_COUNT) segcnt_r <= cfg_data[3:0];
      if (st_r == S_IDLE && in_ch.valid && in_ch.data.action == ACT_SEGWR) begin
        org_r[SW'(in_ch.data.seg_index)] <= EW'(in_ch.data.seg_origin);
        end_r[SW'(in_ch.data.seg_index)] <= EW'(in_ch.data.seg_end);
        perm_r[SW'(in_ch.data.seg_index)] <=
          {in_ch.data.seg_write_ok, in_ch.data.seg_read_ok};
        algn_r[SW'(in_ch.data.seg_index)] <= GW'(in_ch.data.seg_align);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        it_r <= in_ch.data;
        len_r <= (in_ch.data.access_len > LEN_W'(MAX_ACCESS_BYTES)) ?
                 LW'(MAX_ACCESS_BYTES) : LW'(in_ch.data.access_len);
        base_r <= (EW + 1)'(in_ch.data.addr[AW-1:0]);
        si_r <= '0;
        found_r <= 1'b0;
        alg_r <= GW'(1);
        status_r <= ST_OK;
        eaddr_r <= '0;
        ld_r <= '0;
        bi_r <= '0;
      end
      S_SRCH1: begin
        if (e_cur > {1'b0, lim}) status_r <= ST_OOM;
        else if (SCW'(si_r) < cnt_lim && hit) begin
          found_r <= 1'b1;
          seg_r <= si_r;
          if (!(it_r.action == ACT_LOAD ? perm_r[si_r][0] : perm_r[si_r][1]))
            status_r <= ST_PERM;
          alg_r <= (algn_r[si_r] == '0) ? GW'(1) : algn_r[si_r];
        end else si_r <= si_r + 1'b1;
      end
      S_DIVW: if (!div_busy) begin
        si_r <= '0;
        base_r <= prod[EW:0];
      end
      S_SRCH2: begin
        if (status_r == ST_OK && prod[EW:0] != (EW + 1)'(it_r.addr[AW-1:0])) begin
          if (e_cur > {1'b0, lim}) status_r <= ST_MOVED;
          else if (SCW'(si_r) < cnt_lim && hit) begin
            if (!found_r || si_r != seg_r) status_r <= ST_MOVED;
          end else begin
            si_r <= si_r + 1'b1;
            if (SCW'(si_r) + 1'b1 >= cnt_lim && found_r) status_r <= ST_MOVED;
          end
        end
      end
      S_MEM: begin
        if (status_r == ST_OK && bi_r < len_r && it_r.action == ACT_STORE)
          mem[maddr] <= it_r.store_data[8*BW'(bi_r) +: 8];
        rd_r <= mem[maddr];
      end
      S_MEMW: begin
        if (status_r == ST_OK) begin
          if (bi_r < len_r) begin
            if (it_r.action == ACT_LOAD) ld_r[8*BW'(bi_r) +: 8] <= rd_r;
            bi_r <= bi_r + 1'b1;
          end else eaddr_r <= SEGADDR_W'(e_cur);
        end
      end
      default: ;
    endcase
  end

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data));
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
      !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
      (out_ch.valid && out_ch.data.status != ST_OK) |->
        (out_ch.data.end_addr == '0 && out_ch.data.load_data == '0))
    else $error("error result carries data");
endmodule
